// ----- rtl/sha_pkg.sv -----
// sha-256 stream hasher package: round constants, initial hash, shared types
// used by controller, datapath and top level
`default_nettype none
package sha_pkg;

  localparam int WordW = 32;

  typedef struct packed {
    logic load_byte;   // write byte into block buffer
    logic load_pad;    // write padding byte
    logic load_len;    // write length bytes into tail
    logic zero_head;   // clear first 56 bytes
    logic start;       // load round vars from chain
    logic round;       // run one round
    logic fold;        // add round vars into chain
    logic reinit;      // chain back to initial values
    logic shift_out;   // rotate chain for output
  } sha_cmd_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
          32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
          32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
          32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
          32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
          32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
          32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
          32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
          32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
          32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
          32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
          32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sha256_stream_hasher.sv -----
// sha-256 stream hasher top level: controller plus datapath
// depends on sha_pkg, sha_ctrl, sha_datapath
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | op, data_byte
//   out     | output    | out_valid/out_stall | digest_word, word_index, last
//
// a byte that does not finish a block is taken while idle and the hasher stays idle
// a byte that fills a block runs start, 64 rounds, fold before the next byte is taken
// end of message runs one or two blocks, then eight digest words, one per taken cycle
// rst is synchronous and returns the chain to the initial hash and the count to zero
// out_stall holds the current digest word; no input is taken until all eight leave
`default_nettype none
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);

  sha_cmd_t    cmd;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic [63:0] bit_len;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .op, .out_stall, .in_stall, .out_valid,
    .word_index, .last, .cmd, .pos, .rnd, .bit_len
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .pos, .rnd, .data_byte, .bit_len, .head_word(digest_word)
  );

endmodule
`default_nettype wire

// ----- rtl/sha_datapath.sv -----
// sha-256 datapath: chaining words, round variables, schedule window that also buffers the block
// depends on sha_pkg; driven by sha_ctrl commands
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sha_cmd_t    cmd,
  input  wire logic [5:0]  pos,
  input  wire logic [5:0]  rnd,
  input  wire logic [7:0]  data_byte,
  input  wire logic [63:0] bit_len,
  output logic [31:0]      head_word
);

  logic [31:0] chain [8];
  logic [31:0] rv [8];
  logic [31:0] win [16];
  logic [31:0] w, t1, t2, s0, s1;

  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w = (rnd < 6'd16) ? win[0] : (s1 + win[9] + s0 + win[0]);
    t1 = rv[7] + (rotr(rv[4], 6) ^ rotr(rv[4], 11) ^ rotr(rv[4], 25))
       + ((rv[4] & rv[5]) ^ (~rv[4] & rv[6])) + round_const(rnd) + w;
    t2 = (rotr(rv[0], 2) ^ rotr(rv[0], 13) ^ rotr(rv[0], 22))
       + ((rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]));
  end

  // bytes are packed big-endian straight into the window
  // window rotates so that entry 0 is w[t] while t < 16 and w[t-16] after that
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      win[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= data_byte;
    end
    if (cmd.load_pad) begin
      for (int i = 0; i < 64; i++) begin
        if (i[5:0] == pos) win[i[5:2]][{~i[1:0], 3'b000} +: 8] <= 8'h80;
        else if (i[5:0] > pos) win[i[5:2]][{~i[1:0], 3'b000} +: 8] <= 8'h00;
      end
    end
    if (cmd.zero_head) begin
      for (int i = 0; i < 14; i++) win[i] <= 32'h0;
    end
    if (cmd.load_len) begin
      win[14] <= bit_len[63:32];
      win[15] <= bit_len[31:0];
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) rv[i] <= chain[i];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w;
      rv[7] <= rv[6];
      rv[6] <= rv[5];
      rv[5] <= rv[4];
      rv[4] <= rv[3] + t1;
      rv[3] <= rv[2];
      rv[2] <= rv[1];
      rv[1] <= rv[0];
      rv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + rv[i];
    end else if (cmd.shift_out) begin
      for (int i = 0; i < 7; i++) chain[i] <= chain[i + 1];
      chain[7] <= chain[0];
    end else if (cmd.reinit) begin
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
    end
  end

  assign head_word = chain[0];

endmodule
`default_nettype wire

// ----- rtl/sha_ctrl.sv -----
// sha-256 controller: byte counter, round counter, block and output sequencing
// depends on sha_pkg; commands sha_datapath
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        op,
  input  wire logic        out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output logic [2:0]       word_index,
  output logic             last,
  output sha_cmd_t         cmd,
  output logic [5:0]       pos,
  output logic [5:0]       rnd,
  output logic [63:0]      bit_len
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_ROUND, ST_FOLD, ST_LEN, ST_EMIT
  } state_t;

  state_t      state;
  logic [60:0] byte_count;
  logic        final_blk;
  logic        need_len;
  logic        accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign pos      = byte_count[5:0];
  assign bit_len  = {byte_count, 3'b000};
  assign last     = (word_index == 3'd7);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_byte = accept && !op;
        cmd.load_pad  = accept && op;
        cmd.load_len  = accept && op && (pos <= 6'd55);
      end
      ST_START: cmd.start = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold  = 1'b1;
      ST_LEN: begin
        cmd.zero_head = 1'b1;
        cmd.load_len  = 1'b1;
      end
      ST_EMIT: begin
        cmd.shift_out = out_valid && !out_stall && !last;
        cmd.reinit    = out_valid && !out_stall && last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_count <= '0;
      final_blk  <= 1'b0;
      need_len   <= 1'b0;
      rnd        <= '0;
      out_valid  <= 1'b0;
      word_index <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && !op) begin
            byte_count <= byte_count + 61'd1;
            if (pos == 6'd63) begin
              final_blk <= 1'b0;
              need_len  <= 1'b0;
              state     <= ST_START;
            end
          end else if (accept && op) begin
            final_blk <= (pos <= 6'd55);
            need_len  <= (pos > 6'd55);
            state     <= ST_START;
          end
        end
        ST_START: begin
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (need_len) begin
            state <= ST_LEN;
          end else if (final_blk) begin
            out_valid  <= 1'b1;
            word_index <= '0;
            state      <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_LEN: begin
          need_len  <= 1'b0;
          final_blk <= 1'b1;
          state     <= ST_START;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            word_index <= word_index + 3'd1;
            if (last) begin
              out_valid  <= 1'b0;
              byte_count <= '0;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sha_checker.sv -----
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends only on the top level's ports
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last
);

  a_no_input_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during digest output");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (word_index == 3'd7))) else $error("last flag mismatch");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest word order broken");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word))
    else $error("stalled word changed");

endmodule

bind sha256_stream_hasher sha_checker u_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .digest_word, .word_index, .last
);
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for sha256_stream_hasher: byte words in, digest words out, checked
// against a sha-256 predictor kept in the testbench; depends on sha_pkg and the rtl
`timescale 1ns / 1ps
module tb;
  import sha_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_BYTE;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lst;
  } digest_exp_t;

  digest_exp_t digest_q[$];
  int          n_fail = 0;
  int          n_words = 0;
  int          n_msgs = 0;
  int          n_sent = 0;
  int          burst_left = 0;
  int          stall_mode = 0;

  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [60:0] nbytes;

  sha256_stream_hasher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] kconst(int t);
    logic [31:0] k[64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
          32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
          32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
          32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
          32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
          32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
          32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
          32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
          32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
          32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
          32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
          32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  task automatic chain_reset();
    for (int i = 0; i < 8; i++) chain[i] = init_hash(3'(i));
    nbytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic predict_word(logic o, logic [7:0] b);
    int unsigned pos;
    logic [63:0] bits;
    digest_exp_t e;
    pos = nbytes[5:0];
    if (o == OP_BYTE) begin
      blk[pos] = b;
      if (pos == 63) compress_block();
      nbytes = nbytes + 61'd1;
    end else begin
      bits = {nbytes, 3'b000};
      blk[pos] = 8'h80;
      for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
      if (pos > 55) begin
        compress_block();
        for (int i = 0; i < 56; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        e.word = chain[i]; e.idx = 3'(i); e.lst = (i == 7);
        digest_q.push_back(e);
      end
      chain_reset();
      n_msgs++;
    end
  endtask

  task automatic send_word(logic o, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= o;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(o, b);
    n_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(OP_BYTE, 8'($urandom));
    send_word(OP_END, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("digest word with nothing expected: %h", digest_word);
          n_fail++;
        end else begin
          digest_exp_t e;
          e = digest_q.pop_front();
          if (digest_word !== e.word) begin
            $error("digest_word expected %h got %h", e.word, digest_word); n_fail++;
          end
          if (word_index !== e.idx) begin
            $error("word_index expected %0d got %0d", e.idx, word_index); n_fail++;
          end
          if (last !== e.lst) begin
            $error("last expected %0b got %0b", e.lst, last); n_fail++;
          end
        end
        n_words++;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 49) == 0) stall_mode = $urandom_range(0, 2);
    end
  end

  task automatic test_empty_and_fixed();
    send_word(OP_END, 8'hff);
    send_word(OP_BYTE, 8'h61); send_word(OP_BYTE, 8'h62); send_word(OP_BYTE, 8'h63);
    send_word(OP_END, 8'h00);
    send_word(OP_BYTE, 8'hff); send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'haa); send_word(OP_BYTE, 8'h55);
    send_word(OP_END, 8'h00);
  endtask

  task automatic test_block_edges();
    send_message(56);
    send_message(64);
  endtask

  task automatic test_random_messages();
    int start;
    start = n_sent;
    while (n_sent - start < 20) begin
      send_message($urandom_range(0, 12));
    end
  endtask

  initial begin
    chain_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_fixed();
    test_block_edges();
    test_random_messages();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d words in %0d messages, checked %0d digest words",
             n_sent, n_msgs, n_words);
    $display("covered empty message, two-block padding, full-block messages and short random lengths with random stalls");
    if (n_fail == 0) $display("PASS sha256_stream_hasher");
    else $display("FAIL sha256_stream_hasher");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL sha256_stream_hasher");
    $finish;
  end
endmodule
